// ===== hw/rtl/lobm_pkg.sv =====
// Shared types and constants of the limit order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int unsigned ORDER_SLOTS    = 64;
  localparam int unsigned IDX_BITS       = $clog2(ORDER_SLOTS);
  localparam int unsigned PRICE_BITS     = 16;
  localparam int unsigned ID_BITS        = 32;
  localparam int unsigned QTY_BITS       = 32;
  localparam int unsigned ARR_BITS       = 32;
  localparam int unsigned IN_TDATA_BITS  = 88;
  localparam int unsigned OUT_TDATA_BITS = 120;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_RESTED    = 3'd0,
    STAT_DONE      = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_SHRUNK    = 3'd3,
    STAT_MOVED     = 3'd4,
    STAT_UNKNOWN   = 3'd5,
    STAT_FULL      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_MOD,
    S_SCAN,
    S_FILL,
    S_REST,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [ARR_BITS-1:0]   arr;
  } rec_t;

  localparam int unsigned REC_BITS = $bits(rec_t);

  typedef struct packed {
    mode_e                 mode;
    logic [ID_BITS-1:0]    req_id;
    logic                  side;
    logic                  is_limit;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   quantity;
  } req_t;

  typedef struct packed {
    logic                  is_trade;
    logic [ID_BITS-1:0]    buyer_id;
    logic [ID_BITS-1:0]    seller_id;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_qty;
    status_e               status;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    rec_t                wdata;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Limit order book matcher top level: stream ports, slot memory and sequencer.
//
// Input stream s_axis_*: one word per request (add, cancel or modify).
// Output stream m_axis_*: one word per fill; the status of the request rides
// on the last word (tlast), or on a single non-trade word if nothing filled.
// The request port takes a new word only once the previous request has
// handed its final word to the output register.
// Sequencing: every fill costs one scan of all ORDER_SLOTS slots through
// the slot memory's single read port plus one fill state. A cancel or
// modify scans once for the id first. Mode three is dropped with no output.
// Reset clears every slot valid bit and the arrival counter at once; the
// slot memory itself holds no reset and needs no clearing pass.
// A stalled receiver holds the output word; the sequencer waits on it
// before pushing the next fill or the final word.
`default_nettype none
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // req_id[31:0], side[32], is_limit[33], price[49:34], quantity[81:50]
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]                s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // buyer_id[31:0], seller_id[63:32], trade_price[79:64], trade_qty[111:80], status[114:112]
  output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // is_trade[0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  req_t     req;
  res_t     res;
  ram_req_t ram_req;
  rec_t     ram_rdata;

  assign req.mode     = mode_e'(s_axis_tuser);
  assign req.req_id   = s_axis_tdata[31:0];
  assign req.side     = s_axis_tdata[32];
  assign req.is_limit = s_axis_tdata[33];
  assign req.price    = s_axis_tdata[49:34];
  assign req.quantity = s_axis_tdata[81:50];

  lobm_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (ORDER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  lobm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  assign m_axis_tdata = {5'b0, res.status, res.trade_qty, res.trade_price,
                         res.seller_id, res.buyer_id};
  assign m_axis_tuser = res.is_trade;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  a_nontrade_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("non-trade word without tlast");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[114:112] == 3'd0)
    else $error("status on a word that is not last");

  a_nontrade_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[111:0] == '0)
    else $error("non-trade word carries fill fields");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lobm_ram.sv =====
// Order slot memory: one write port, one read port with registered read data.
`default_nettype none
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lobm_core.sv =====
// Matching sequencer: slot scans, fills, resting and result output register.
`default_nettype none
module lobm_core
  import lobm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire req_t     in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output res_t          out_res_o,
  output ram_req_t      ram_req_o,
  input  wire rec_t     ram_rdata_i
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ORDER_SLOTS - 1);

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [ID_BITS-1:0]     id_q, id_d;
  logic                   side_q, side_d;
  logic                   lim_q, lim_d;
  logic [PRICE_BITS-1:0]  price_q, price_d;
  logic [QTY_BITS-1:0]    qty_q, qty_d;
  status_e                code_q, code_d;
  status_e                status_q, status_d;
  logic [IDX_BITS-1:0]    cnt_q, cnt_d;
  logic                   issue_q, issue_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IDX_BITS-1:0]    rd_idx_q, rd_idx_d;
  logic                   best_vld_q, best_vld_d;
  logic [IDX_BITS-1:0]    best_idx_q, best_idx_d;
  rec_t                   best_q, best_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [ARR_BITS-1:0]    ctr_q, ctr_d;
  logic                   pend_vld_q, pend_vld_d;
  res_t                   pend_q, pend_d;
  logic                   out_vld_q, out_vld_d;
  res_t                   out_q, out_d;

  logic                   free_vld;
  logic [IDX_BITS-1:0]    free_idx;
  logic                   out_free;
  logic                   hit;
  logic                   better;
  logic                   cross_fail;
  logic [QTY_BITS-1:0]    fill;
  logic [ARR_BITS-1:0]    age_new, age_best;
  res_t                   trade;

  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_vld = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    age_new  = ctr_q - ram_rdata_i.arr;
    age_best = ctr_q - best_q.arr;
    if (!best_vld_q) begin
      better = 1'b1;
    end else if (ram_rdata_i.price != best_q.price) begin
      better = side_q ? (ram_rdata_i.price > best_q.price)
                      : (ram_rdata_i.price < best_q.price);
    end else begin
      better = age_new > age_best;
    end
    cross_fail = lim_q && (side_q ? (price_q > best_q.price) : (price_q < best_q.price));
    fill = (qty_q < best_q.qty) ? qty_q : best_q.qty;
    trade             = '0;
    trade.is_trade    = 1'b1;
    trade.buyer_id    = side_q ? best_q.id : id_q;
    trade.seller_id   = side_q ? id_q : best_q.id;
    trade.trade_price = best_q.price;
    trade.trade_qty   = fill;
    trade.status      = STAT_RESTED;
  end

  assign hit      = rd_vld_q && valid_q[rd_idx_q];
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    id_d       = id_q;
    side_d     = side_q;
    lim_d      = lim_q;
    price_d    = price_q;
    qty_d      = qty_q;
    code_d     = code_q;
    status_d   = status_q;
    cnt_d      = cnt_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = cnt_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    valid_d    = valid_q;
    ctr_d      = ctr_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    in_ready_o = 1'b0;
    ram_req_o       = '0;
    ram_req_o.waddr = best_idx_q;
    ram_req_o.wdata = best_q;
    ram_req_o.raddr = cnt_q;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    if ((state_q == S_FIND || state_q == S_SCAN) && issue_q) begin
      ram_req_o.re = 1'b1;
      rd_vld_d     = 1'b1;
      if (cnt_q == LAST_IDX) begin
        issue_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d     = in_req_i.mode;
          id_d       = in_req_i.req_id;
          side_d     = in_req_i.side;
          lim_d      = in_req_i.is_limit;
          price_d    = in_req_i.price;
          qty_d      = in_req_i.quantity;
          code_d     = STAT_RESTED;
          cnt_d      = '0;
          issue_d    = 1'b1;
          best_vld_d = 1'b0;
          case (in_req_i.mode)
            MODE_ADD: begin
              if (in_req_i.quantity == '0) begin
                issue_d = 1'b0;
                state_d = S_REST;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_CANCEL, MODE_MODIFY: state_d = S_FIND;
            default: issue_d = 1'b0;
          endcase
        end
      end
      S_FIND: begin
        if (hit && !best_vld_q && ram_rdata_i.id == id_q) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = ram_rdata_i;
        end
        if (rd_vld_q && rd_idx_q == LAST_IDX) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        state_d = S_FIN;
        if (!best_vld_q) begin
          status_d = STAT_UNKNOWN;
        end else if (mode_q == MODE_CANCEL || qty_q == '0) begin
          valid_d[best_idx_q] = 1'b0;
          status_d            = STAT_CANCELLED;
        end else if (price_q == best_q.price && qty_q <= best_q.qty) begin
          ram_req_o.we        = 1'b1;
          ram_req_o.wdata.qty = qty_q;
          status_d            = STAT_SHRUNK;
        end else begin
          valid_d[best_idx_q] = 1'b0;
          side_d     = best_q.side;
          lim_d      = 1'b1;
          code_d     = STAT_MOVED;
          cnt_d      = '0;
          issue_d    = 1'b1;
          best_vld_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit && ram_rdata_i.side != side_q && better) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = ram_rdata_i;
        end
        if (rd_vld_q && rd_idx_q == LAST_IDX) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (!best_vld_q || cross_fail) begin
          state_d = S_REST;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = pend_q;
          end
          ram_req_o.we        = 1'b1;
          ram_req_o.wdata.qty = best_q.qty - fill;
          if (best_q.qty == fill) begin
            valid_d[best_idx_q] = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_d     = trade;
          qty_d      = qty_q - fill;
          if (qty_q == fill) begin
            state_d = S_REST;
          end else begin
            cnt_d      = '0;
            issue_d    = 1'b1;
            best_vld_d = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end
      S_REST: begin
        state_d = S_FIN;
        if (qty_q != '0 && lim_q) begin
          if (free_vld) begin
            ram_req_o.we          = 1'b1;
            ram_req_o.waddr       = free_idx;
            ram_req_o.wdata.id    = id_q;
            ram_req_o.wdata.side  = side_q;
            ram_req_o.wdata.price = price_q;
            ram_req_o.wdata.qty   = qty_q;
            ram_req_o.wdata.arr   = ctr_q;
            valid_d[free_idx]     = 1'b1;
            ctr_d                 = ctr_q + 1'b1;
            status_d              = code_q;
          end else begin
            status_d = STAT_FULL;
          end
        end else begin
          status_d = STAT_DONE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = pend_vld_q ? pend_q : '0;
          out_d.status = status_q;
          out_d.last   = 1'b1;
          pend_vld_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      issue_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      valid_q    <= '0;
      ctr_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      valid_q    <= valid_d;
      ctr_q      <= ctr_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    id_q       <= id_d;
    side_q     <= side_d;
    lim_q      <= lim_d;
    price_q    <= price_d;
    qty_q      <= qty_d;
    code_q     <= code_d;
    status_q   <= status_d;
    cnt_q      <= cnt_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule
`default_nettype wire
